/* rtl/core/lcs_pkg.sv */
// Shared constants, function codes and controller interface types for the
// LCS similarity core. Depends on nothing; every other file imports it.
`default_nettype none
package lcs_pkg;

  localparam int unsigned MAX_LEN_DEF = 64;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned SIM_W       = FRAC_W + 1;
  localparam int unsigned BIT_CNT_W   = $clog2(FRAC_W + 1);

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CAND   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic fin_rd;
    logic div_init;
    logic div_step;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic div_done;
  } ctrl_status_t;

endpackage
`default_nettype wire

/* rtl/core/lcs_datapath.sv */
// Datapath of the LCS similarity core: reference and score memories, the
// cell update, and the bit-serial ratio divider. Depends on lcs_pkg.
`default_nettype none
module lcs_datapath #(
  parameter int unsigned MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  lcs_pkg::ctrl_cmd_t           cmd_i,
  output lcs_pkg::ctrl_status_t        status_o,
  input  wire [lcs_pkg::FUNC_W-1:0]    func_i,
  input  wire [lcs_pkg::CHAR_W-1:0]    char_value_i,
  output logic [lcs_pkg::LEN_W-1:0]    lcs_length_o,
  output logic [lcs_pkg::LEN_W-1:0]    ref_length_o,
  output logic [lcs_pkg::SIM_W-1:0]    similarity_o,
  output logic                         ref_overflow_o
);
  import lcs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [CHAR_W-1:0] ref_mem [MAX_LEN];
  logic [CW-1:0]     row_mem [MAX_LEN];

  logic [CW-1:0]        count_q, count_d;
  logic                 cand_q, cand_d;
  logic                 ovf_q, ovf_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [AW-1:0]        wr_idx_q;
  logic                 pend_q;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;

  logic [CHAR_W-1:0]    char_q;
  logic [CW-1:0]        diag_q, left_q, lcs_q;
  logic [CHAR_W-1:0]    ref_rd_q;
  logic [CW-1:0]        row_rd_q;
  logic [CW:0]          rem_q;
  logic [SIM_W-1:0]     quot_q;

  logic [AW-1:0]        last_idx;
  logic [AW-1:0]        rd_addr;
  logic                 append_we;
  logic [AW-1:0]        append_idx;
  logic [CW-1:0]        cell_val;
  logic                 row_we;
  logic [AW-1:0]        row_waddr;
  logic [CW-1:0]        row_wdata;
  logic [CW:0]          trial;
  logic                 fits;
  logic [CW-1:0]        lcs_init;

  assign last_idx   = AW'(count_q - CW'(1));
  assign rd_addr    = cmd_i.scan_step ? idx_q : last_idx;
  assign append_idx = AW'(count_q);
  assign append_we  = cmd_i.accept && (func_i == FUNC_APPEND) && !cand_q &&
                      (count_q < CW'(MAX_LEN));

  always_comb begin
    if (ref_rd_q == char_q) begin
      cell_val = diag_q + CW'(1);
    end else if (row_rd_q >= left_q) begin
      cell_val = row_rd_q;
    end else begin
      cell_val = left_q;
    end
  end

  assign row_we    = append_we || pend_q;
  assign row_waddr = pend_q ? wr_idx_q : append_idx;
  assign row_wdata = pend_q ? cell_val : '0;

  assign trial    = (bit_cnt_q == BIT_CNT_W'(FRAC_W)) ? rem_q : {rem_q[CW-1:0], 1'b0};
  assign fits     = trial >= {1'b0, count_q};
  assign lcs_init = (count_q == '0) ? '0 : row_rd_q;

  always_ff @(posedge clk_i) begin
    if (append_we) begin
      ref_mem[append_idx] <= char_value_i;
    end
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (cmd_i.scan_step || cmd_i.fin_rd) begin
      ref_rd_q <= ref_mem[rd_addr];
      row_rd_q <= row_mem[rd_addr];
    end
  end

  always_comb begin
    count_d   = count_q;
    cand_d    = cand_q;
    ovf_d     = ovf_q;
    idx_d     = idx_q;
    bit_cnt_d = bit_cnt_q;
    if (append_we) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.accept && (func_i == FUNC_APPEND) && !cand_q &&
        (count_q >= CW'(MAX_LEN))) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.accept && (func_i == FUNC_CAND)) begin
      cand_d = 1'b1;
      idx_d  = '0;
    end
    if (cmd_i.scan_step) begin
      idx_d = idx_q + AW'(1);
    end
    if (cmd_i.div_init) begin
      bit_cnt_d = BIT_CNT_W'(FRAC_W);
    end
    if (cmd_i.div_step) begin
      bit_cnt_d = bit_cnt_q - BIT_CNT_W'(1);
    end
    if (cmd_i.clear) begin
      count_d = '0;
      cand_d  = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cand_q    <= 1'b0;
      ovf_q     <= 1'b0;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      bit_cnt_q <= '0;
    end else begin
      count_q   <= count_d;
      cand_q    <= cand_d;
      ovf_q     <= ovf_d;
      idx_q     <= idx_d;
      pend_q    <= cmd_i.scan_step;
      bit_cnt_q <= bit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (func_i == FUNC_CAND)) begin
      char_q <= char_value_i;
      diag_q <= '0;
      left_q <= '0;
    end else if (pend_q) begin
      diag_q <= row_rd_q;
      left_q <= cell_val;
    end
    if (cmd_i.scan_step) begin
      wr_idx_q <= idx_q;
    end
    if (cmd_i.div_init) begin
      lcs_q  <= lcs_init;
      rem_q  <= {1'b0, lcs_init};
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= fits ? (trial - {1'b0, count_q}) : trial;
      quot_q <= {quot_q[SIM_W-2:0], fits};
    end
  end

  assign status_o.count_zero = (count_q == '0);
  assign status_o.scan_last  = (idx_q == last_idx);
  assign status_o.div_done   = (bit_cnt_q == '0);

  assign lcs_length_o   = LEN_W'(lcs_q);
  assign ref_length_o   = LEN_W'(count_q);
  assign similarity_o   = ((count_q != '0) && cand_q) ? quot_q : '0;
  assign ref_overflow_o = ovf_q;

endmodule
`default_nettype wire

/* rtl/core/lcs_controller.sv */
// Controller state machine of the LCS similarity core: accepts words and
// sequences the row walk, the final read and the divider. Depends on lcs_pkg.
`default_nettype none
module lcs_controller (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire [lcs_pkg::FUNC_W-1:0] func_i,
  input  lcs_pkg::ctrl_status_t     status_i,
  output lcs_pkg::ctrl_cmd_t        cmd_o,
  output logic                      busy_o,
  output logic                      done_o
);
  import lcs_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_FLUSH    = 3'd2;
  localparam logic [2:0] S_FIN_RD   = 3'd3;
  localparam logic [2:0] S_DIV_INIT = 3'd4;
  localparam logic [2:0] S_DIV      = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          case (func_i)
            FUNC_CAND: begin
              if (!status_i.count_zero) begin
                state_d = S_SCAN;
              end
            end
            FUNC_FINISH: state_d = S_FIN_RD;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: state_d = S_IDLE;
      S_FIN_RD: begin
        cmd_o.fin_rd = 1'b1;
        state_d      = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.clear = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_EMIT);

endmodule
`default_nettype wire

/* rtl/core/lcs_similarity_core.sv */
// Top level of the LCS similarity core; depends on lcs_pkg, lcs_controller and lcs_datapath.
// A reference byte is stored as it is accepted. A candidate byte walks the held row one cell
// per cycle, one read and one write a cycle, then passes a flush state; with no reference byte
// held it is accepted with no walk. A finish word's result is on the ports after the row read,
// the divider load and 17 quotient bits; the next word is taken the cycle after the result. The
// receiver cannot stall results. Reset clears the counts and flags at once, not the memories.
`default_nettype none
module lcs_similarity_core #(
  parameter int unsigned MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire [lcs_pkg::FUNC_W-1:0]    func_i,
  input  wire [lcs_pkg::CHAR_W-1:0]    char_value_i,
  output logic                         done_o,
  output logic [lcs_pkg::LEN_W-1:0]    lcs_length_o,
  output logic [lcs_pkg::LEN_W-1:0]    ref_length_o,
  output logic [lcs_pkg::SIM_W-1:0]    similarity_o,
  output logic                         ref_overflow_o
);
  import lcs_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  lcs_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .func_i   (func_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  lcs_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .func_i         (func_i),
    .char_value_i   (char_value_i),
    .lcs_length_o   (lcs_length_o),
    .ref_length_o   (ref_length_o),
    .similarity_o   (similarity_o),
    .ref_overflow_o (ref_overflow_o)
  );

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe lasted more than one cycle.");

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("Result shown while a new word could be accepted.");

  a_sim_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (similarity_o <= SIM_W'(1 << FRAC_W)))
    else $error("Similarity ratio exceeds one.");

  a_scan_no_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_step |-> !cmd.div_step && !cmd.clear)
    else $error("Row walk overlaps the divider.");

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for lcs_similarity_core: a directed table followed by
// random reference and candidate strings, each result checked against a predictor
// or the table's fixed score. Depends on lcs_pkg and the lcs_similarity_core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lcs_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int ROW_LEN     = MAX_LEN_DEF;
  localparam int RAND_WORDS  = 1500;
  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 64;
  localparam int DIR_ROWS    = 23;

  typedef struct packed {
    logic [LEN_W-1:0] lcs;
    logic [LEN_W-1:0] ref_len;
    logic [SIM_W-1:0] sim;
    logic             ovf;
  } score_t;

  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic [CHAR_W-1:0] ch;
    logic [6:0]        rep;
    logic              fixed;
    score_t            want;
  } dir_row_t;

  localparam score_t NO_SCORE = '0;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [FUNC_W-1:0] func_i;
  logic [CHAR_W-1:0] char_value_i;
  logic              done_o;
  logic [LEN_W-1:0]  lcs_length_o;
  logic [LEN_W-1:0]  ref_length_o;
  logic [SIM_W-1:0]  similarity_o;
  logic              ref_overflow_o;

  lcs_similarity_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .char_value_i   (char_value_i),
    .done_o         (done_o),
    .lcs_length_o   (lcs_length_o),
    .ref_length_o   (ref_length_o),
    .similarity_o   (similarity_o),
    .ref_overflow_o (ref_overflow_o)
  );

  logic [CHAR_W-1:0] ref_bytes  [ROW_LEN];
  logic [LEN_W-1:0]  row_scores [ROW_LEN];
  int unsigned       ref_count;
  bit                cand_seen;
  bit                ovf_seen;
  score_t            pending_scores [$];
  int                mismatches;
  int                words_sent;
  longint            cycles;
  dir_row_t          dir_tbl [DIR_ROWS];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit predict_word(input logic [FUNC_W-1:0] fn,
                                      input logic [CHAR_W-1:0] ch, output score_t res);
    logic [LEN_W-1:0]        diag;
    logic [LEN_W-1:0]        left;
    logic [LEN_W-1:0]        up;
    logic [LEN_W+FRAC_W-1:0] num;
    int unsigned             k;
    res = NO_SCORE;
    case (fn)
      FUNC_APPEND: begin
        if (!cand_seen) begin
          if (ref_count < ROW_LEN) begin
            ref_bytes[ref_count]  = ch;
            row_scores[ref_count] = '0;
            ref_count++;
          end else begin
            ovf_seen = 1'b1;
          end
        end
      end
      FUNC_CAND: begin
        cand_seen = 1'b1;
        diag = '0;
        left = '0;
        for (k = 0; k < ref_count; k++) begin
          up = row_scores[k];
          if (ref_bytes[k] == ch) row_scores[k] = diag + 1'b1;
          else row_scores[k] = (up >= left) ? up : left;
          diag = up;
          left = row_scores[k];
        end
      end
      FUNC_FINISH: begin
        res.lcs     = (ref_count > 0) ? row_scores[ref_count-1] : '0;
        res.ref_len = LEN_W'(ref_count);
        num         = {res.lcs, {FRAC_W{1'b0}}};
        res.sim     = (ref_count > 0 && cand_seen) ? SIM_W'(num / ref_count) : '0;
        res.ovf     = ovf_seen;
        ref_count   = 0;
        cand_seen   = 1'b0;
        ovf_seen    = 1'b0;
        for (k = 0; k < ROW_LEN; k++) row_scores[k] = '0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [CHAR_W-1:0] ch,
                           input bit fixed, input score_t want);
    score_t res;
    @(negedge clk_i);
    start_i      <= 1'b1;
    func_i       <= fn;
    char_value_i <= ch;
    do @(posedge clk_i); while (busy_o);
    if (predict_word(fn, ch, res)) pending_scores.push_back(fixed ? want : res);
    if (fn != FUNC_UNUSED) words_sent++;
  endtask

  task automatic idle_maybe(input bit quiet);
    if (!quiet && $urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 24)) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
    end
  endtask

  task automatic drain_scores();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input logic [FUNC_W-1:0] fn, input logic [CHAR_W-1:0] ch);
    idle_maybe(words_sent >= 600 && words_sent < 900);
    send_word(fn, ch, 1'b0, NO_SCORE);
  endtask

  function automatic int pick_len(input bit allow_zero);
    int r;
    r = $urandom_range(99);
    if (allow_zero && r < 5) return 0;
    if (r < 70) return $urandom_range(1, 10);
    if (r < 92) return $urandom_range(11, 64);
    return $urandom_range(64, 70);
  endfunction

  task automatic random_string_pair();
    int                nref;
    int                ncand;
    bit                narrow;
    logic [CHAR_W-1:0] base;
    int                i;
    nref   = pick_len(1'b1);
    ncand  = pick_len(1'b1);
    narrow = ($urandom_range(3) != 0);
    base   = CHAR_W'($urandom_range(255));
    for (i = 0; i < nref; i++)
      send_random(FUNC_APPEND, narrow ? base ^ CHAR_W'($urandom_range(3))
                                      : CHAR_W'($urandom_range(255)));
    for (i = 0; i < ncand; i++) begin
      if ($urandom_range(99) < 4) send_random(FUNC_APPEND, CHAR_W'($urandom_range(255)));
      if ($urandom_range(99) < 3) send_random(FUNC_UNUSED, CHAR_W'($urandom_range(255)));
      send_random(FUNC_CAND, narrow ? base ^ CHAR_W'($urandom_range(3))
                                    : CHAR_W'($urandom_range(255)));
    end
    send_random(FUNC_FINISH, CHAR_W'($urandom_range(255)));
  endtask

  always @(posedge clk_i) begin : score_check
    score_t want;
    score_t seen;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else if (rst_ni && done_o) begin
      seen = '{lcs_length_o, ref_length_o, similarity_o, ref_overflow_o};
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: lcs %0d ref %0d sim %0d ovf %0d",
                   seen.lcs, seen.ref_len, seen.sim, seen.ovf);
      end else begin
        want = pending_scores.pop_front();
        if (seen.lcs !== want.lcs || seen.ref_len !== want.ref_len ||
            seen.sim !== want.sim || seen.ovf !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: lcs %0d/%0d ref %0d/%0d sim %0d/%0d ovf %0d/%0d (exp/act)",
                     want.lcs, seen.lcs, want.ref_len, seen.ref_len,
                     want.sim, seen.sim, want.ovf, seen.ovf);
        end
      end
    end
  end

  initial begin : stimulus
    int i;
    int r;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    func_i       = FUNC_APPEND;
    char_value_i = '0;
    ref_count    = 0;
    cand_seen    = 1'b0;
    ovf_seen     = 1'b0;
    mismatches   = 0;
    words_sent   = 0;
    cycles       = 0;
    dir_tbl = '{
      '{FUNC_FINISH, 8'h00, 7'd1,  1'b1, '{7'd0,  7'd0,  17'd0,     1'b0}},
      '{FUNC_CAND,   8'h00, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_FINISH, 8'hFF, 7'd1,  1'b1, '{7'd0,  7'd0,  17'd0,     1'b0}},
      '{FUNC_APPEND, 8'hFF, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_FINISH, 8'h00, 7'd1,  1'b1, '{7'd0,  7'd1,  17'd0,     1'b0}},
      '{FUNC_APPEND, 8'hFF, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_CAND,   8'hFF, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_FINISH, 8'h00, 7'd1,  1'b1, '{7'd1,  7'd1,  17'd65536, 1'b0}},
      '{FUNC_APPEND, 8'h00, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_APPEND, 8'hAA, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_APPEND, 8'h55, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_CAND,   8'h55, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_UNUSED, 8'hC3, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_CAND,   8'h00, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_APPEND, 8'h12, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_CAND,   8'hAA, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_FINISH, 8'h7E, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_APPEND, 8'h41, 7'd65, 1'b0, NO_SCORE},
      '{FUNC_CAND,   8'h41, 7'd1,  1'b0, NO_SCORE},
      '{FUNC_FINISH, 8'h00, 7'd1,  1'b1, '{7'd1,  7'd64, 17'd1024,  1'b1}},
      '{FUNC_APPEND, 8'h3C, 7'd64, 1'b0, NO_SCORE},
      '{FUNC_CAND,   8'h3C, 7'd64, 1'b0, NO_SCORE},
      '{FUNC_FINISH, 8'h00, 7'd1,  1'b1, '{7'd64, 7'd64, 17'd65536, 1'b0}}
    };
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      for (r = 0; r < dir_tbl[i].rep; r++) begin
        idle_maybe(1'b0);
        send_word(dir_tbl[i].fn, dir_tbl[i].ch, dir_tbl[i].fixed, dir_tbl[i].want);
      end
    end
    drain_scores();

    words_sent = 0;
    while (words_sent < RAND_WORDS) begin
      if ($urandom_range(99) < 8) begin
        send_random(FUNC_W'($urandom_range(3)), CHAR_W'($urandom_range(255)));
      end else begin
        random_string_pair();
        if ($urandom_range(99) < 3) drain_scores();
      end
    end
    send_random(FUNC_FINISH, '0);

    drain_scores();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_scores.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* lcs_similarity_core.f */
rtl/core/lcs_pkg.sv
rtl/core/lcs_datapath.sv
rtl/core/lcs_controller.sv
rtl/core/lcs_similarity_core.sv
dv/testbench.sv
